// ===== sv/mips_subset_processor_step_macros.svh =====
// assertion macros for the mips subset step core
// no dependencies
`ifndef MIPS_SUBSET_PROCESSOR_STEP_MACROS_SVH
`define MIPS_SUBSET_PROCESSOR_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define MSP_ASSERT_IMPL(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define MSP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define MSP_ASSERT_IMPL(label, clk, rst, cond)
`define MSP_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== sv/msp_pkg.sv =====
// shared types and constants for the mips subset step core
// no dependencies
package msp_pkg;
   localparam logic [31:0] TEXT_BASE = 32'h0040_0000;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_ANDI    = 6'd12;
   localparam logic [5:0] OP_ORI     = 6'd13;
   localparam logic [5:0] OP_LUI     = 6'd15;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_SW      = 6'd43;

   localparam logic [5:0] FN_SLL  = 6'd0;
   localparam logic [5:0] FN_SRL  = 6'd2;
   localparam logic [5:0] FN_JR   = 6'd8;
   localparam logic [5:0] FN_ADDU = 6'd33;
   localparam logic [5:0] FN_SUBU = 6'd35;
   localparam logic [5:0] FN_AND  = 6'd36;
   localparam logic [5:0] FN_OR   = 6'd37;
   localparam logic [5:0] FN_SLT  = 6'd42;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_OP  = 2'd1;
   localparam logic [1:0] ST_BAD_ADR = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_EXEC, S_MEM, S_WB, S_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_we;     // write zero at the clear counter
      logic load_we;      // host word write
      logic fetch;        // read instruction word
      logic decode;       // latch instruction, read registers
      logic exec;         // compute result and address
      logic mem;          // data access
      logic commit;       // update registers, pc, result
      logic wr_result;    // build a result without executing
      logic rsp_load;     // move result to output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic halted;
      logic fetch_bad;
      logic exec_halt;
   } status_type;
endpackage

// ===== sv/mips_subset_processor_step.sv =====
// top level of the mips subset step core
// depends on msp_pkg, msp_ctrl, msp_datapath and the assertion macros
//
// req channel: tdata carries cmd, load_index and load_word (one bit of cmd
// selects a memory word write or the execution of one instruction).
// rsp channel: one item per request with status, pc, fetched word and the
// register or memory word that changed.
// a write item or a step on a halted core builds its result at accept and
// then loads the output register; an executed step runs fetch, decode,
// execute, memory and writeback in the controller (a bad pc skips from
// fetch to writeback), reading the single port memory at fetch and at
// memory; the next item is taken in the cycle after the output register
// is loaded. after reset the memory is zeroed one word a cycle, with
// req_tready low; r29 resets to the top of memory and pc to 0x00400000.
// a stalled receiver holds the result in the output register and the core
// waits; an unsupported instruction or bad address halts until reset.
`include "mips_subset_processor_step_macros.svh"
module mips_subset_processor_step #(
   parameter int INSTR_WORDS = 1024,
   parameter int DATA_WORDS  = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,  // cmd, load_index[10:0], load_word[31:0], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], next_pc, executed_word, reg_written, reg_number[4:0],
   // reg_value, mem_written, mem_byte_address, mem_value, zero pad
   output logic [175:0] rsp_tdata
);
   localparam int MEM_WORDS = INSTR_WORDS + DATA_WORDS;

   msp_pkg::cmd_type    cmd;
   msp_pkg::status_type status;
   logic [1:0]  r_status;
   logic [31:0] r_pc, r_word, r_rval, r_maddr, r_mval;
   logic        r_rw, r_mw;
   logic [4:0]  r_rnum;
   logic        rsp_valid_ff;

   msp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_cmd(req_tdata[0]), .rsp_busy(rsp_valid_ff && !rsp_tready),
      .status(status), .cmd(cmd)
   );

   msp_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_load_index(req_tdata[11:1]), .req_load_word(req_tdata[43:12]),
      .res_status(r_status), .res_next_pc(r_pc), .res_executed_word(r_word),
      .res_reg_written(r_rw), .res_reg_number(r_rnum), .res_reg_value(r_rval),
      .res_mem_written(r_mw), .res_mem_byte_address(r_maddr), .res_mem_value(r_mval)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load)
         rsp_tdata <= {7'd0, r_mval, r_maddr, r_mw, r_rval, r_rnum, r_rw, r_word,
                       r_pc, r_status};
   end

   assign rsp_tvalid = rsp_valid_ff;

   `MSP_ASSERT_IMPL(a_no_overwrite, clock, reset, !(cmd.rsp_load && rsp_valid_ff && !rsp_tready))
   `MSP_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.rsp_load, rsp_valid_ff)
   `MSP_ASSERT_IMPL(a_halt_not_ok, clock, reset, !(cmd.commit && status.exec_halt && status.halted))
endmodule

// ===== sv/msp_ctrl.sv =====
// controller state machine for the mips subset step core
// depends on msp_pkg
module msp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_cmd,
   input  logic                rsp_busy,
   input  msp_pkg::status_type status,
   output msp_pkg::cmd_type    cmd
);
   msp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msp_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msp_pkg::S_CLEAR: if (status.clear_done) state_in = msp_pkg::S_IDLE;
         msp_pkg::S_IDLE: begin
            if (req_tvalid) begin
               if (!req_cmd || status.halted) state_in = msp_pkg::S_OUT;
               else state_in = msp_pkg::S_FETCH;
            end
         end
         msp_pkg::S_FETCH:
            state_in = status.fetch_bad ? msp_pkg::S_WB : msp_pkg::S_DECODE;
         msp_pkg::S_DECODE: state_in = msp_pkg::S_EXEC;
         msp_pkg::S_EXEC: state_in = msp_pkg::S_MEM;
         msp_pkg::S_MEM: state_in = msp_pkg::S_WB;
         msp_pkg::S_WB: state_in = msp_pkg::S_OUT;
         msp_pkg::S_OUT: if (!rsp_busy) state_in = msp_pkg::S_IDLE;
         default: state_in = msp_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         msp_pkg::S_CLEAR: cmd.clear_we = 1'b1;
         msp_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (!req_cmd) begin
                  cmd.load_we = 1'b1;
                  cmd.wr_result = 1'b1;
               end else if (status.halted) begin
                  cmd.wr_result = 1'b1;
               end
            end
         end
         msp_pkg::S_FETCH: cmd.fetch = 1'b1;
         msp_pkg::S_DECODE: cmd.decode = 1'b1;
         msp_pkg::S_EXEC: cmd.exec = 1'b1;
         msp_pkg::S_MEM: cmd.mem = 1'b1;
         msp_pkg::S_WB: cmd.commit = 1'b1;
         msp_pkg::S_OUT: cmd.rsp_load = !rsp_busy;
         default: cmd = '0;
      endcase
   end
endmodule

// ===== sv/msp_datapath.sv =====
// datapath of the mips subset step core: memory, register file, alu, pc
// depends on msp_pkg
module msp_datapath #(
   parameter int MEM_WORDS = 2048
) (
   input  logic                clock,
   input  logic                reset,
   input  msp_pkg::cmd_type    cmd,
   output msp_pkg::status_type status,
   input  logic [10:0]         req_load_index,
   input  logic [31:0]         req_load_word,
   output logic [1:0]          res_status,
   output logic [31:0]         res_next_pc,
   output logic [31:0]         res_executed_word,
   output logic                res_reg_written,
   output logic [4:0]          res_reg_number,
   output logic [31:0]         res_reg_value,
   output logic                res_mem_written,
   output logic [31:0]         res_mem_byte_address,
   output logic [31:0]         res_mem_value
);
   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam logic [31:0] SP_RESET = 32'(msp_pkg::TEXT_BASE + 32'(4 * MEM_WORDS));

   logic [31:0] mem [MEM_WORDS];
   logic [31:0] regs_ff [32];
   logic [31:0] mem_rd_ff;
   logic [AW:0] clr_ff;
   logic [31:0] pc_ff;
   logic        halted_ff;
   logic [1:0]  halt_code_ff;
   logic [31:0] ir_ff, a_ff, b_ff, val_ff, npc_ff, maddr_ff;
   logic [4:0]  dreg_ff;
   logic        wr_ff, mw_ff, bad_op_ff, bad_adr_ff;

   // word slot check
   function automatic logic slot_ok(input logic [31:0] addr);
      logic [31:0] off;
      off = addr - msp_pkg::TEXT_BASE;
      return (off[1:0] == 2'b00) && ({2'b00, off[31:2]} < 32'(MEM_WORDS));
   endfunction

   logic [31:0] off_pc, off_m;
   assign off_pc = pc_ff - msp_pkg::TEXT_BASE;
   assign off_m  = maddr_ff - msp_pkg::TEXT_BASE;

   assign status.clear_done = (clr_ff == (AW + 1)'(MEM_WORDS - 1));
   assign status.halted     = halted_ff;
   assign status.fetch_bad  = !slot_ok(pc_ff);
   assign status.exec_halt  = bad_op_ff || bad_adr_ff;

   // single port word memory
   always_ff @(posedge clock) begin
      if (cmd.clear_we) begin
         mem[clr_ff[AW-1:0]] <= '0;
      end else if (cmd.load_we) begin
         if ({21'd0, req_load_index} < 32'(MEM_WORDS))
            mem[req_load_index[AW-1:0]] <= req_load_word;
      end else if (cmd.mem && mw_ff && !bad_op_ff && slot_ok(maddr_ff)) begin
         mem[off_m[AW+1:2]] <= b_ff;
      end
      if (cmd.fetch) mem_rd_ff <= mem[off_pc[AW+1:2]];
      else if (cmd.mem) mem_rd_ff <= mem[off_m[AW+1:2]];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_we && !status.clear_done) clr_ff <= clr_ff + 1'b1;
   end

   logic [5:0]  op, fn;
   logic [31:0] zimm, simm, pc4;
   assign op   = ir_ff[31:26];
   assign fn   = ir_ff[5:0];
   assign zimm = {16'd0, ir_ff[15:0]};
   assign simm = {{16{ir_ff[15]}}, ir_ff[15:0]};
   assign pc4  = pc_ff + 32'd4;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) regs_ff[i] <= (i == 29) ? SP_RESET : '0;
         pc_ff <= msp_pkg::TEXT_BASE;
         halted_ff <= 1'b0;
         halt_code_ff <= msp_pkg::ST_OK;
      end else begin
         if (cmd.decode) begin
            ir_ff <= mem_rd_ff;
            a_ff  <= regs_ff[mem_rd_ff[25:21]];
            b_ff  <= regs_ff[mem_rd_ff[20:16]];
         end
         if (cmd.exec) begin
            wr_ff <= 1'b1; mw_ff <= 1'b0; bad_op_ff <= 1'b0; bad_adr_ff <= 1'b0;
            dreg_ff <= ir_ff[20:16]; val_ff <= '0; npc_ff <= pc4;
            maddr_ff <= a_ff + simm;
            case (op)
               msp_pkg::OP_SPECIAL: begin
                  dreg_ff <= ir_ff[15:11];
                  case (fn)
                     msp_pkg::FN_ADDU: val_ff <= a_ff + b_ff;
                     msp_pkg::FN_SUBU: val_ff <= a_ff - b_ff;
                     msp_pkg::FN_SLL:  val_ff <= b_ff << ir_ff[10:6];
                     msp_pkg::FN_SRL:  val_ff <= b_ff >> ir_ff[10:6];
                     msp_pkg::FN_AND:  val_ff <= a_ff & b_ff;
                     msp_pkg::FN_OR:   val_ff <= a_ff | b_ff;
                     msp_pkg::FN_SLT:  val_ff <= {31'd0, $signed(a_ff) < $signed(b_ff)};
                     msp_pkg::FN_JR: begin wr_ff <= 1'b0; npc_ff <= a_ff; end
                     default: begin wr_ff <= 1'b0; bad_op_ff <= 1'b1; end
                  endcase
               end
               msp_pkg::OP_J, msp_pkg::OP_JAL: begin
                  npc_ff <= {pc4[31:28], ir_ff[25:0], 2'b00};
                  wr_ff <= (op == msp_pkg::OP_JAL);
                  dreg_ff <= 5'd31; val_ff <= pc4;
               end
               msp_pkg::OP_BEQ, msp_pkg::OP_BNE: begin
                  wr_ff <= 1'b0;
                  if ((a_ff == b_ff) == (op == msp_pkg::OP_BEQ))
                     npc_ff <= pc4 + {simm[29:0], 2'b00};
               end
               msp_pkg::OP_ADDIU: val_ff <= a_ff + simm;
               msp_pkg::OP_ANDI:  val_ff <= a_ff & zimm;
               msp_pkg::OP_ORI:   val_ff <= a_ff | zimm;
               msp_pkg::OP_LUI:   val_ff <= {ir_ff[15:0], 16'd0};
               msp_pkg::OP_LW: ;
               msp_pkg::OP_SW: begin wr_ff <= 1'b0; mw_ff <= 1'b1; end
               default: begin wr_ff <= 1'b0; bad_op_ff <= 1'b1; end
            endcase
         end
         if (cmd.mem && (op == msp_pkg::OP_LW || op == msp_pkg::OP_SW) && !bad_op_ff)
            bad_adr_ff <= !slot_ok(maddr_ff);
         if (cmd.commit) begin
            if (status.fetch_bad) begin
               halted_ff <= 1'b1; halt_code_ff <= msp_pkg::ST_BAD_ADR;
            end else if (bad_op_ff) begin
               halted_ff <= 1'b1; halt_code_ff <= msp_pkg::ST_BAD_OP;
            end else if (bad_adr_ff) begin
               halted_ff <= 1'b1; halt_code_ff <= msp_pkg::ST_BAD_ADR;
            end else begin
               pc_ff <= npc_ff;
               if (wr_ff && dreg_ff != 5'd0)
                  regs_ff[dreg_ff] <= (op == msp_pkg::OP_LW) ? mem_rd_ff : val_ff;
            end
         end
      end
   end

   // result register, built at commit or for write and halted items
   logic ok_c;
   assign ok_c = !status.fetch_bad && !bad_op_ff && !bad_adr_ff;
   always_ff @(posedge clock) begin
      if (cmd.wr_result) begin
         res_status <= halt_code_ff; res_next_pc <= pc_ff;
         res_executed_word <= '0; res_reg_written <= 1'b0; res_reg_number <= '0;
         res_reg_value <= '0; res_mem_written <= 1'b0;
         res_mem_byte_address <= '0; res_mem_value <= '0;
      end else if (cmd.commit) begin
         res_status <= status.fetch_bad ? msp_pkg::ST_BAD_ADR :
                       bad_op_ff ? msp_pkg::ST_BAD_OP :
                       bad_adr_ff ? msp_pkg::ST_BAD_ADR : msp_pkg::ST_OK;
         res_next_pc <= ok_c ? npc_ff : pc_ff;
         res_executed_word <= status.fetch_bad ? '0 : ir_ff;
         res_reg_written <= ok_c && wr_ff && dreg_ff != 5'd0;
         res_reg_number <= (ok_c && wr_ff && dreg_ff != 5'd0) ? dreg_ff : '0;
         res_reg_value <= (ok_c && wr_ff && dreg_ff != 5'd0) ?
                          ((op == msp_pkg::OP_LW) ? mem_rd_ff : val_ff) : '0;
         res_mem_written <= ok_c && mw_ff;
         res_mem_byte_address <= (ok_c && mw_ff) ? maddr_ff : '0;
         res_mem_value <= (ok_c && mw_ff) ? b_ff : '0;
      end
   end
endmodule
